// ===== sv/rac_pkg.sv =====
package rac_pkg;

	localparam int FIELD_W = 32;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [2:0] CMD_LOAD = 3'd0;
	localparam logic [2:0] CMD_ADD  = 3'd1;
	localparam logic [2:0] CMD_SUB  = 3'd2;
	localparam logic [2:0] CMD_MUL  = 3'd3;
	localparam logic [2:0] CMD_DIV  = 3'd4;

	localparam logic [1:0] MSEL_P0 = 2'd0;
	localparam logic [1:0] MSEL_P1 = 2'd1;
	localparam logic [1:0] MSEL_P2 = 2'd2;

	typedef struct packed {
		logic [2:0]                 cmd;
		logic signed [FIELD_W-1:0]  operand_numerator;
		logic signed [FIELD_W-1:0]  operand_denominator;
	} req_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0]  result_numerator;
		logic signed [FIELD_W-1:0]  result_denominator;
		logic                       overflow;
	} rsp_t;

	typedef struct packed {
		logic       load_in;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       comb;
		logic       gcd_step;
		logic       div_init;
		logic       div_step;
		logic       commit;
	} dp_cmd_t;

	typedef struct packed {
		logic arith;
		logic zero;
		logic gcd_eq;
		logic div_last;
	} dp_sts_t;

endpackage

// ===== sv/rac_dp.sv =====
module rac_dp #(
	parameter int DATA_WIDTH = rac_pkg::DATA_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rac_pkg::dp_cmd_t  cmd,
	output rac_pkg::dp_sts_t  sts,
	input  rac_pkg::req_t     req,
	output rac_pkg::rsp_t     rsp
);

	localparam int W  = DATA_WIDTH;
	localparam int MW = 2 * DATA_WIDTH;
	localparam int KW = $clog2(MW);
	localparam int CW = $clog2(MW);

	typedef struct packed {
		logic          neg;
		logic [MW-1:0] mag;
	} sm_t;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
		return x[W-1] ? (W'(0) - x) : x;
	endfunction

	function automatic sm_t sm_add(input sm_t a, input sm_t b);
		sm_t r;
		if (a.neg == b.neg) begin
			r.mag = a.mag + b.mag;
			r.neg = a.neg;
		end else if (a.mag >= b.mag) begin
			r.mag = a.mag - b.mag;
			r.neg = a.neg;
		end else begin
			r.mag = b.mag - a.mag;
			r.neg = b.neg;
		end
		if (r.mag == '0) begin
			r.neg = 1'b0;
		end
		return r;
	endfunction

	function automatic logic fits(input sm_t v);
		logic [MW-1:0] lim;
		lim = MW'(1) << (W - 1);
		return v.neg ? (v.mag <= lim) : (v.mag < lim);
	endfunction

	function automatic logic [W-1:0] to_bits(input sm_t v);
		logic [MW-1:0] b;
		b = v.neg ? (MW'(0) - v.mag) : v.mag;
		return b[W-1:0];
	endfunction

	logic [2:0]    cmd_q;
	logic [W-1:0]  opn_q, opd_q;
	logic [W-1:0]  acc_n_q, acc_d_q;
	sm_t           p0_q, p1_q, p2_q;
	logic [MW-1:0] n_mag_q, d_mag_q;
	logic          n_neg_q, d_neg_q;
	logic [MW-1:0] a_q, b_q, g_q;
	logic [KW-1:0] k_q;
	logic [MW-1:0] rn_q, rd_q;
	logic [CW-1:0] cnt_q;
	rac_pkg::rsp_t rsp_q;

	logic          is_arith;
	logic          x_neg, y_neg;
	logic [W-1:0]  x_mag, y_mag;
	sm_t           prod;
	sm_t           t_sub, n_comb, d_comb, n_fin, d_fin;
	logic [MW-1:0] gdiff_ab, gdiff_ba;
	logic [MW:0]   tn, td, gx;
	logic          ge_n, ge_d;
	logic [W-1:0]  acc_n_nx, acc_d_nx;
	logic          ovf_nx;

	assign is_arith = (cmd_q == rac_pkg::CMD_ADD) || (cmd_q == rac_pkg::CMD_SUB) ||
		(cmd_q == rac_pkg::CMD_MUL) || (cmd_q == rac_pkg::CMD_DIV);

	// shared multiplier operand select
	always_comb begin
		x_neg = acc_n_q[W-1];
		x_mag = mag_of(acc_n_q);
		y_neg = opd_q[W-1];
		y_mag = mag_of(opd_q);
		unique case (cmd.mul_sel)
			rac_pkg::MSEL_P0: begin
				if (cmd_q == rac_pkg::CMD_MUL) begin
					y_neg = opn_q[W-1];
					y_mag = mag_of(opn_q);
				end
			end
			rac_pkg::MSEL_P1: begin
				x_neg = opn_q[W-1];
				x_mag = mag_of(opn_q);
				y_neg = acc_d_q[W-1];
				y_mag = mag_of(acc_d_q);
			end
			rac_pkg::MSEL_P2: begin
				x_neg = acc_d_q[W-1];
				x_mag = mag_of(acc_d_q);
				if (cmd_q == rac_pkg::CMD_DIV) begin
					y_neg = opn_q[W-1];
					y_mag = mag_of(opn_q);
				end
			end
			default: begin
			end
		endcase
		prod.mag = MW'(x_mag) * MW'(y_mag);
		prod.neg = (prod.mag != '0) && (x_neg != y_neg);
	end

	always_comb begin
		t_sub = p1_q;
		if (cmd_q == rac_pkg::CMD_SUB && p1_q.mag != '0) begin
			t_sub.neg = !p1_q.neg;
		end
		if (cmd_q == rac_pkg::CMD_ADD || cmd_q == rac_pkg::CMD_SUB) begin
			n_comb = sm_add(p0_q, t_sub);
		end else begin
			n_comb = p0_q;
		end
		d_comb = p2_q;
	end

	assign gdiff_ab = a_q - b_q;
	assign gdiff_ba = b_q - a_q;

	assign gx   = {1'b0, g_q};
	assign tn   = {rn_q, n_mag_q[MW-1]};
	assign td   = {rd_q, d_mag_q[MW-1]};
	assign ge_n = tn >= gx;
	assign ge_d = td >= gx;

	always_comb begin
		n_fin.neg = n_neg_q;
		n_fin.mag = n_mag_q;
		d_fin.neg = d_neg_q;
		d_fin.mag = d_mag_q;
		acc_n_nx = acc_n_q;
		acc_d_nx = acc_d_q;
		ovf_nx   = 1'b0;
		if (cmd_q == rac_pkg::CMD_LOAD) begin
			acc_n_nx = opn_q;
			acc_d_nx = opd_q;
		end else if (is_arith) begin
			acc_n_nx = to_bits(n_fin);
			acc_d_nx = to_bits(d_fin);
			ovf_nx   = !(fits(n_fin) && fits(d_fin));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_n_q <= '0;
			acc_d_q <= '0;
		end else if (cmd.commit) begin
			acc_n_q <= acc_n_nx;
			acc_d_q <= acc_d_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q <= req.cmd;
			opn_q <= req.operand_numerator[W-1:0];
			opd_q <= req.operand_denominator[W-1:0];
		end
		if (cmd.mul_en) begin
			unique case (cmd.mul_sel)
				rac_pkg::MSEL_P0: p0_q <= prod;
				rac_pkg::MSEL_P1: p1_q <= prod;
				default:          p2_q <= prod;
			endcase
		end
		if (cmd.comb) begin
			n_mag_q <= n_comb.mag;
			n_neg_q <= n_comb.neg;
			d_mag_q <= d_comb.mag;
			d_neg_q <= d_comb.neg;
			a_q     <= n_comb.mag;
			b_q     <= d_comb.mag;
			k_q     <= '0;
		end
		if (cmd.gcd_step) begin
			priority if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= gdiff_ab >> 1;
			end else begin
				b_q <= gdiff_ba >> 1;
			end
		end
		if (cmd.div_init) begin
			g_q   <= a_q << k_q;
			rn_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rn_q    <= ge_n ? MW'(tn - gx) : tn[MW-1:0];
			rd_q    <= ge_d ? MW'(td - gx) : td[MW-1:0];
			n_mag_q <= {n_mag_q[MW-2:0], ge_n};
			d_mag_q <= {d_mag_q[MW-2:0], ge_d};
			cnt_q   <= cnt_q + CW'(1);
		end
		if (cmd.commit) begin
			rsp_q.result_numerator   <= rac_pkg::FIELD_W'(signed'(acc_n_nx));
			rsp_q.result_denominator <= rac_pkg::FIELD_W'(signed'(acc_d_nx));
			rsp_q.overflow           <= ovf_nx;
		end
	end

	assign sts.arith    = is_arith;
	assign sts.zero     = (n_mag_q == '0) || (d_mag_q == '0);
	assign sts.gcd_eq   = (a_q == b_q);
	assign sts.div_last = (cnt_q == CW'(MW - 1));
	assign rsp          = rsp_q;

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gcd_step |-> (a_q != '0) && (b_q != '0))
		else $error("gcd operand hit zero");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (g_q != '0))
		else $error("divide by zero gcd");

	a_exact_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_arith && $past(cmd.div_step)) |-> (rn_q == '0) && (rd_q == '0))
		else $error("reduction left a remainder");

endmodule

// ===== sv/rac_ctrl.sv =====
module rac_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rac_pkg::dp_cmd_t  dcmd,
	input  rac_pkg::dp_sts_t  sts
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL0 = 3'd1;
	localparam logic [2:0] S_MUL1 = 3'd2;
	localparam logic [2:0] S_MUL2 = 3'd3;
	localparam logic [2:0] S_COMB = 3'd4;
	localparam logic [2:0] S_GCD  = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q, state_nx;
	logic       rsp_valid_q;
	logic       accept;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_nx = state_q;
		dcmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					dcmd.load_in = 1'b1;
					state_nx     = S_MUL0;
				end
			end
			S_MUL0: begin
				if (sts.arith) begin
					dcmd.mul_en  = 1'b1;
					dcmd.mul_sel = rac_pkg::MSEL_P0;
					state_nx     = S_MUL1;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_MUL1: begin
				dcmd.mul_en  = 1'b1;
				dcmd.mul_sel = rac_pkg::MSEL_P1;
				state_nx     = S_MUL2;
			end
			S_MUL2: begin
				dcmd.mul_en  = 1'b1;
				dcmd.mul_sel = rac_pkg::MSEL_P2;
				state_nx     = S_COMB;
			end
			S_COMB: begin
				dcmd.comb = 1'b1;
				state_nx  = S_GCD;
			end
			S_GCD: begin
				priority if (sts.zero) begin
					state_nx = S_DONE;
				end else if (sts.gcd_eq) begin
					dcmd.div_init = 1'b1;
					state_nx      = S_DIV;
				end else begin
					dcmd.gcd_step = 1'b1;
				end
			end
			S_DIV: begin
				dcmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					dcmd.commit = 1'b1;
					state_nx    = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (dcmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.commit |=> rsp_valid && (state_q == S_IDLE))
		else $error("commit did not present a word");

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && $past(state_q) == S_GCD) |-> $past(sts.gcd_eq && !sts.zero))
		else $error("divide entered without gcd");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cmd_ready)
		else $error("second word taken while busy");

endmodule

// ===== sv/rational_accumulator_alu.sv =====
// channel  | valid      | ready      | data      | type
// request  | cmd_valid  | cmd_ready  | cmd_data  | rac_pkg::req_t
// response | rsp_valid  | rsp_ready  | rsp_data  | rac_pkg::rsp_t
//
// Load and unused commands: from accept through the MUL0 and DONE states to the response.
// Arithmetic: MUL0, MUL1, MUL2 and COMB, then the binary gcd loop and the bit-serial
// divider unless the numerator or denominator is zero, then DONE.
// One word in flight; a new word is taken while the response waits.
// arst_n clears the accumulator to 0/0 and drops rsp_valid.
module rational_accumulator_alu #(
	parameter int DATA_WIDTH = rac_pkg::DATA_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  rac_pkg::req_t  cmd_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rac_pkg::rsp_t  rsp_data
);

	rac_pkg::dp_cmd_t dcmd;
	rac_pkg::dp_sts_t sts;

	rac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.dcmd      (dcmd),
		.sts       (sts)
	);

	rac_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dcmd),
		.sts    (sts),
		.req    (cmd_data),
		.rsp    (rsp_data)
	);

endmodule
